/* src/spq_pkg.sv */
// spq_pkg: shared types, codes and defaults for the stable priority queue
// used by spq_cell and stable_priority_queue; depends on nothing
package spq_pkg;

  localparam int CAPACITY_DEFAULT = 64;
  localparam int COUNT_OUT_W      = 7;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_REMOVE = 1'b1;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_DUP   = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;
  localparam logic [1:0] ST_FULL  = 2'd3;

  typedef struct packed {
    logic        [15:0] id;
    logic        [15:0] kind;
    logic signed [31:0] prio;
  } entry_t;

  typedef struct packed {
    logic cmp;
    logic ins;
    logic rem;
  } cell_ctl_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_EXEC
  } state_t;

endpackage

/* src/spq_cell.sv */
// spq_cell: one slot of the sorted shift-register queue
// depends on spq_pkg; instantiated in a row by stable_priority_queue
module spq_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  spq_pkg::cell_ctl_t ctl,
  input  spq_pkg::entry_t    new_ent,
  input  spq_pkg::entry_t    prev_ent,
  input  logic               prev_valid,
  input  logic               prev_le,
  input  spq_pkg::entry_t    next_ent,
  input  logic               next_valid,
  output spq_pkg::entry_t    ent,
  output logic               valid,
  output logic               le,
  output logic               match
);

  spq_pkg::entry_t ent_r;
  logic            valid_r;
  logic            le_r;
  logic            match_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      le_r    <= 1'b0;
      match_r <= 1'b0;
    end else begin
      if (ctl.cmp) begin
        le_r    <= valid_r && (ent_r.prio <= new_ent.prio);
        match_r <= valid_r && (ent_r.id == new_ent.id);
      end
      if (ctl.ins && !le_r) begin
        valid_r <= prev_le ? 1'b1 : prev_valid;
      end else if (ctl.rem) begin
        valid_r <= next_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.ins && !le_r) begin
      ent_r <= prev_le ? new_ent : prev_ent;
    end else if (ctl.rem) begin
      ent_r <= next_ent;
    end
  end

  assign ent   = ent_r;
  assign valid = valid_r;
  assign le    = le_r;
  assign match = match_r;

endmodule

/* src/stable_priority_queue.sv */
// stable_priority_queue: sorted queue built from a row of spq_cell slots
// depends on spq_pkg and spq_cell
// the result is registered when S_EXEC commits, after the compare state S_CMP that follows acceptance
// one transaction at a time: each passes through accept, compare in every cell and shift before the next is taken
// a waiting result that is not yet taken holds the shift, and new input is accepted only in S_IDLE
// reset: synchronous active low, empties the queue; slot contents need no clearing
module stable_priority_queue #(
  parameter int CAPACITY = spq_pkg::CAPACITY_DEFAULT
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_command,
  input  logic        [15:0] in_item_id,
  input  logic        [15:0] in_kind,
  input  logic signed [31:0] in_priority_req,
  output logic               out_valid,
  input  logic               out_ready,
  output logic         [1:0] out_status,
  output logic         [6:0] out_entry_count,
  output logic        [15:0] out_head_id,
  output logic        [15:0] out_head_kind,
  output logic signed [31:0] out_head_priority
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  spq_pkg::state_t    state_r, state_nxt;
  logic               cmd_r;
  spq_pkg::entry_t    new_ent_r;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  spq_pkg::cell_ctl_t ctl;

  spq_pkg::entry_t    cell_ent [CAPACITY];
  logic [CAPACITY-1:0] cell_valid;
  logic [CAPACITY-1:0] cell_le;
  logic [CAPACITY-1:0] cell_match;

  logic               accept;
  logic               commit;
  logic               dup;
  logic               full;
  logic               empty;
  logic               ins_do;
  logic               rem_do;
  logic [1:0]         status;
  logic [CNT_W+spq_pkg::COUNT_OUT_W-1:0] cnt_ext;

  logic               out_valid_r;
  logic [1:0]         out_status_r;
  logic [6:0]         out_count_r;
  spq_pkg::entry_t    out_head_r;

  assign in_ready = (state_r == spq_pkg::S_IDLE);
  assign accept   = in_valid && in_ready;

  assign dup   = |cell_match;
  assign full  = (cnt_r == CNT_W'(CAPACITY));
  assign empty = (cnt_r == '0);

  always_comb begin
    state_nxt = state_r;
    commit    = 1'b0;
    unique case (state_r)
      spq_pkg::S_IDLE: begin
        if (accept) state_nxt = spq_pkg::S_CMP;
      end
      spq_pkg::S_CMP: begin
        state_nxt = spq_pkg::S_EXEC;
      end
      spq_pkg::S_EXEC: begin
        commit = !out_valid_r || out_ready;
        if (commit) state_nxt = spq_pkg::S_IDLE;
      end
      default: begin
        state_nxt = spq_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    ins_do  = commit && (cmd_r == spq_pkg::CMD_INSERT) && !dup && !full;
    rem_do  = commit && (cmd_r == spq_pkg::CMD_REMOVE) && !empty;
    ctl.cmp = (state_r == spq_pkg::S_CMP);
    ctl.ins = ins_do;
    ctl.rem = rem_do;
    if (cmd_r == spq_pkg::CMD_INSERT) begin
      status = dup ? spq_pkg::ST_DUP : (full ? spq_pkg::ST_FULL : spq_pkg::ST_OK);
    end else begin
      status = empty ? spq_pkg::ST_EMPTY : spq_pkg::ST_OK;
    end
    cnt_nxt = cnt_r;
    if (ins_do) cnt_nxt = cnt_r + CNT_W'(1);
    else if (rem_do) cnt_nxt = cnt_r - CNT_W'(1);
    cnt_ext = {{spq_pkg::COUNT_OUT_W{1'b0}}, cnt_nxt};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= spq_pkg::S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      if (commit) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r          <= in_command;
      new_ent_r.id   <= in_item_id;
      new_ent_r.kind <= in_kind;
      new_ent_r.prio <= in_priority_req;
    end
    if (commit) begin
      out_status_r <= status;
      out_count_r  <= cnt_ext[spq_pkg::COUNT_OUT_W-1:0];
      out_head_r   <= rem_do ? cell_ent[0] : '0;
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    spq_pkg::entry_t prev_ent;
    spq_pkg::entry_t next_ent;
    logic            prev_valid;
    logic            prev_le;
    logic            next_valid;

    if (i == 0) begin : g_first
      assign prev_ent   = new_ent_r;
      assign prev_valid = 1'b0;
      assign prev_le    = 1'b1;
    end else begin : g_mid
      assign prev_ent   = cell_ent[i-1];
      assign prev_valid = cell_valid[i-1];
      assign prev_le    = cell_le[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign next_ent   = new_ent_r;
      assign next_valid = 1'b0;
    end else begin : g_inner
      assign next_ent   = cell_ent[i+1];
      assign next_valid = cell_valid[i+1];
    end

    spq_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctl        (ctl),
      .new_ent    (new_ent_r),
      .prev_ent   (prev_ent),
      .prev_valid (prev_valid),
      .prev_le    (prev_le),
      .next_ent   (next_ent),
      .next_valid (next_valid),
      .ent        (cell_ent[i]),
      .valid      (cell_valid[i]),
      .le         (cell_le[i]),
      .match      (cell_match[i])
    );
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_entry_count   = out_count_r;
  assign out_head_id       = out_head_r.id;
  assign out_head_kind     = out_head_r.kind;
  assign out_head_priority = out_head_r.prio;

endmodule
